// ===== hdl/tlbmmu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbmmu_pkg
// Shared types and constants of the demand-paging MMU: word formats,
// controller commands and datapath status.
// ----------------------------------------------------------------------------
package tlbmmu_pkg;

    localparam int NUM_PAGES  = 256;
    localparam int NUM_FRAMES = 128;
    localparam int TLB_SIZE   = 16;
    localparam int PAGE_SIZE  = 256;

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int OFF_W   = $clog2(PAGE_SIZE);
    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int TLB_W   = $clog2(TLB_SIZE);
    localparam int CNT_W   = FRAME_W + 1;
    localparam int VA_W    = 16;
    localparam int PA_W    = 15;

    typedef struct packed {
        logic [VA_W-1:0] virt_addr;
        logic            write_req;
    } t_in_word;

    typedef struct packed {
        logic [PA_W-1:0]   paddr;
        logic              tlb_hit;
        logic              page_fault;
        logic              write_back;
        logic [PAGE_W-1:0] evicted_page;
        logic              evict_valid;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic look;
        logic pt_rd;
        logic evict_rd;
        logic evict_dirty;
        logic fill;
        logic touch;
        logic unlink;
        logic append;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic pt_valid;
        logic full;
        logic new_frame;
        logic at_tail;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/tlbmmu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbmmu_ctrl
// Sequencer of one translation: tlb lookup, page-table read, eviction,
// tlb fill, lru updates and result hand-off.
// ----------------------------------------------------------------------------
module tlbmmu_ctrl
    import tlbmmu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOOK  = 10'b00_0000_0010,
        S_PTR   = 10'b00_0000_0100,
        S_EVR   = 10'b00_0000_1000,
        S_EVD   = 10'b00_0001_0000,
        S_FILL  = 10'b00_0010_0000,
        S_TOUCH = 10'b00_0100_0000,
        S_LUN   = 10'b00_1000_0000,
        S_LAP   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_status.hit)           n_state = S_TOUCH;
                else if (i_status.pt_valid) n_state = S_PTR;
                else if (i_status.full)     n_state = S_EVR;
                else                        n_state = S_FILL;
            end
            S_PTR: begin
                o_cmd.pt_rd = 1'b1;
                n_state     = S_FILL;
            end
            S_EVR: begin
                o_cmd.evict_rd = 1'b1;
                n_state        = S_EVD;
            end
            S_EVD: begin
                o_cmd.evict_dirty = 1'b1;
                n_state           = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_TOUCH;
            end
            S_TOUCH: begin
                o_cmd.touch = 1'b1;
                if (i_status.new_frame)    n_state = S_LAP;
                else if (i_status.at_tail) n_state = S_DONE;
                else                       n_state = S_LUN;
            end
            S_LUN: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_LAP;
            end
            S_LAP: begin
                o_cmd.append = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/tlbmmu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbmmu_dp
// Storage and datapath: tlb with lru order, page table, frame owners,
// frame lru kept as a doubly linked list, and the output register.
// ----------------------------------------------------------------------------
module tlbmmu_dp
    import tlbmmu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    // current word
    logic [PAGE_W-1:0]  r_page;
    logic [OFF_W-1:0]   r_off;
    logic               r_wr;
    logic [FRAME_W-1:0] r_frame;
    logic [TLB_W-1:0]   r_entry;
    logic               r_hit, r_fault, r_wb, r_evv;
    logic [PAGE_W-1:0]  r_evp;

    // tlb
    logic [TLB_SIZE-1:0] r_tlb_valid;
    logic [PAGE_W-1:0]   r_tlb_page  [TLB_SIZE];
    logic [FRAME_W-1:0]  r_tlb_frame [TLB_SIZE];
    logic [TLB_W-1:0]    r_tlb_ord   [TLB_SIZE];

    // page table and frames
    logic [NUM_PAGES-1:0] r_pt_valid;
    logic [FRAME_W-1:0]   m_pt_frame [NUM_PAGES];
    logic                 m_pt_dirty [NUM_PAGES];
    logic [PAGE_W-1:0]    m_owner    [NUM_FRAMES];
    logic [FRAME_W-1:0]   m_next     [NUM_FRAMES];
    logic [FRAME_W-1:0]   m_prev     [NUM_FRAMES];
    logic [FRAME_W-1:0]   r_frame_rd, r_next_rd, r_prev_rd;
    logic [PAGE_W-1:0]    r_owner_rd;
    logic                 r_dirty_rd;
    logic [CNT_W-1:0]     r_in_use;
    logic [FRAME_W-1:0]   r_head, r_tail;
    logic                 r_list_any;

    logic               r_out_valid;
    t_out_word          r_out;

    logic               full;
    logic               hit;
    logic [TLB_W-1:0]   hit_idx;
    logic [TLB_W-1:0]   fill_idx;
    logic               fill_found;
    logic [TLB_W-1:0]   touch_pos;
    logic [TLB_W-1:0]   n_tlb_ord [TLB_SIZE];

    assign full = r_in_use[CNT_W-1];

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TLB_SIZE; i++) begin
            if (!hit && r_tlb_valid[i] && r_tlb_page[i] == r_page) begin
                hit     = 1'b1;
                hit_idx = TLB_W'(i);
            end
        end
    end

    // least recent invalid entry, else the lru entry
    always_comb begin
        fill_idx   = r_tlb_ord[0];
        fill_found = 1'b0;
        for (int i = 0; i < TLB_SIZE; i++) begin
            if (!fill_found && !r_tlb_valid[r_tlb_ord[i]]) begin
                fill_idx   = r_tlb_ord[i];
                fill_found = 1'b1;
            end
        end
    end

    always_comb begin
        touch_pos = TLB_W'(TLB_SIZE - 1);
        for (int i = TLB_SIZE - 1; i >= 0; i--) begin
            if (r_tlb_ord[i] == r_entry) touch_pos = TLB_W'(i);
        end
        for (int i = 0; i < TLB_SIZE - 1; i++) begin
            if (TLB_W'(i) >= touch_pos) n_tlb_ord[i] = r_tlb_ord[i+1];
            else                        n_tlb_ord[i] = r_tlb_ord[i];
        end
        n_tlb_ord[TLB_SIZE-1] = r_entry;
    end

    assign o_status.hit       = hit;
    assign o_status.pt_valid  = r_pt_valid[r_page];
    assign o_status.full      = full;
    assign o_status.new_frame = r_fault && !r_evv;
    assign o_status.at_tail   = r_list_any && (r_frame == r_tail);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // memory reads, every cycle at addresses that hold still while needed
    always_ff @(posedge i_clk) begin
        r_frame_rd <= m_pt_frame[r_page];
        r_owner_rd <= m_owner[r_head];
        r_dirty_rd <= m_pt_dirty[r_owner_rd];
        r_next_rd  <= m_next[r_frame];
        r_prev_rd  <= m_prev[r_frame];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill && r_fault) begin
            m_pt_frame[r_page] <= r_frame;
            m_owner[r_frame]   <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.touch && (r_wr || r_fault)) m_pt_dirty[r_page] <= r_wr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink && (r_frame != r_head)) begin
            m_next[r_prev_rd] <= r_next_rd;
        end else if (i_cmd.append && r_list_any) begin
            m_next[r_tail] <= r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink) begin
            m_prev[r_next_rd] <= r_prev_rd;
        end else if (i_cmd.append && r_list_any) begin
            m_prev[r_frame] <= r_tail;
        end
    end

    // word registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= i_in.virt_addr[OFF_W +: PAGE_W];
            r_off  <= i_in.virt_addr[OFF_W-1:0];
            r_wr   <= i_in.write_req;
        end
        if (i_cmd.look) begin
            r_hit   <= hit;
            r_fault <= !hit && !r_pt_valid[r_page];
            r_wb    <= 1'b0;
            r_evv   <= !hit && !r_pt_valid[r_page] && full;
            r_evp   <= '0;
            r_entry <= hit_idx;
            if (hit)       r_frame <= r_tlb_frame[hit_idx];
            else if (full) r_frame <= r_head;
            else           r_frame <= r_in_use[FRAME_W-1:0];
        end
        if (i_cmd.pt_rd)       r_frame <= r_frame_rd;
        if (i_cmd.evict_rd)    r_evp   <= r_owner_rd;
        if (i_cmd.evict_dirty) r_wb    <= r_dirty_rd;
        if (i_cmd.fill) begin
            r_entry                <= fill_idx;
            r_tlb_page[fill_idx]   <= r_page;
            r_tlb_frame[fill_idx]  <= r_frame;
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid <= '0;
            r_pt_valid  <= '0;
            r_in_use    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_list_any  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TLB_SIZE; i++) r_tlb_ord[i] <= TLB_W'(i);
        end else begin
            if (i_cmd.look && !hit && !r_pt_valid[r_page] && !full) begin
                r_in_use <= r_in_use + CNT_W'(1);
            end
            if (i_cmd.evict_rd) begin
                r_pt_valid[r_owner_rd] <= 1'b0;
                for (int i = 0; i < TLB_SIZE; i++) begin
                    if (r_tlb_valid[i] && r_tlb_page[i] == r_owner_rd) r_tlb_valid[i] <= 1'b0;
                end
            end
            if (i_cmd.fill) begin
                r_tlb_valid[fill_idx] <= 1'b1;
                if (r_fault) r_pt_valid[r_page] <= 1'b1;
            end
            if (i_cmd.touch) r_tlb_ord <= n_tlb_ord;
            if (i_cmd.unlink && (r_frame == r_head)) r_head <= r_next_rd;
            if (i_cmd.append) begin
                if (!r_list_any) r_head <= r_frame;
                r_tail     <= r_frame;
                r_list_any <= 1'b1;
            end
            if (i_cmd.finish)          r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.paddr        <= PA_W'({r_frame, r_off});
            r_out.tlb_hit      <= r_hit;
            r_out.page_fault   <= r_fault;
            r_out.write_back   <= r_wb;
            r_out.evicted_page <= r_evp;
            r_out.evict_valid  <= r_evv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hdl/tlb_demand_paging_lru_mmu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_demand_paging_lru_mmu
// Demand-paging MMU: 16-entry fully associative tlb, 256-page table,
// 128 frames with lru replacement, one result word per access word.
// ----------------------------------------------------------------------------
// One access at a time, stepped by a sequencer over single-port memories.
// Each access looks up the tlb; a miss reads the page table for a resident
// page, or the owner and dirty bit of the lru frame for a fault with
// eviction, then fills the tlb. Every access touches the tlb lru; a frame
// already most recent then goes to done, a new frame is appended, any other
// is unlinked and appended. The frame lru is a linked list in memory, so
// each move of a frame costs an unlink and an append step. The result
// sits in an output register, so the next access proceeds while it waits;
// a second result holds in its last state until the first one is taken.
module tlb_demand_paging_lru_mmu
    import tlbmmu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out
);

    t_cmd    cmd;
    t_status status;

    tlbmmu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlbmmu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
